>>> hdl/rb2d_pkg.sv
// Shared constants, types and helpers for the 2D rigid body Euler step unit.
`default_nettype none
package rb2d_pkg;

  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int TS_W       = 17;
  localparam int DRAG_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OP_W       = 4;
  localparam int CNT_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_KINEMATIC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_DRAG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_DRAG = 3'd5;

  localparam logic [TS_W-1:0]   TIME_STEP_RST    = 17'd1092;
  localparam logic [DRAG_W-1:0] LINEAR_DRAG_RST  = 31'd6553600;
  localparam logic [DRAG_W-1:0] ANGULAR_DRAG_RST = 31'd3276800;

  // Multiplier operations, issued in this order by the controller.
  localparam logic [OP_W-1:0] MO_AXX  = 4'd0;
  localparam logic [OP_W-1:0] MO_AYY  = 4'd1;
  localparam logic [OP_W-1:0] MO_FL   = 4'd2;
  localparam logic [OP_W-1:0] MO_FA   = 4'd3;
  localparam logic [OP_W-1:0] MO_DPX  = 4'd4;
  localparam logic [OP_W-1:0] MO_DPY  = 4'd5;
  localparam logic [OP_W-1:0] MO_DANG = 4'd6;
  localparam logic [OP_W-1:0] MO_DGX  = 4'd7;
  localparam logic [OP_W-1:0] MO_DGY  = 4'd8;
  localparam logic [OP_W-1:0] MO_MX   = 4'd9;
  localparam logic [OP_W-1:0] MO_MY   = 4'd10;
  localparam logic [CNT_W-1:0] MUL_OPS = 6'd11;

  typedef struct packed {
    logic            issue;
    logic [OP_W-1:0] op;
    logic            load;
    logic            sqrt_init;
    logic            sqrt_step;
    logic            div_init_x;
    logic            div_init_y;
    logic            div_step;
    logic            save_loss_x;
    logic            apply;
    logic            capture;
  } rb2d_cmd_t;

  function automatic logic [WORD_W-1:0] sat34(input logic signed [WORD_W+1:0] v);
    logic [WORD_W-1:0] r;
    if (v > $signed({3'b000, {(WORD_W-1){1'b1}}})) begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < $signed({3'b111, {(WORD_W-1){1'b0}}})) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rb2d_ctrl.sv
// Sequencing state machine for the Euler step unit.
`default_nettype none
module rb2d_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_command,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rb2d_pkg::rb2d_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SQRT  = 3'd2;
  localparam logic [2:0] S_DIVX  = 3'd3;
  localparam logic [2:0] S_DIVY  = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;

  localparam logic [rb2d_pkg::CNT_W-1:0] LAST_BIT = 6'd31;
  localparam logic [rb2d_pkg::CNT_W-1:0] DIVY_END = 6'd32;

  logic [2:0]                   state_r, state_nxt;
  logic [rb2d_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r + 6'd1;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          if (in_command) begin
            cmd.load  = 1'b1;
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (cnt_r == rb2d_pkg::MUL_OPS) begin
          cmd.sqrt_init = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_SQRT;
        end else begin
          cmd.issue = 1'b1;
          cmd.op    = cnt_r[rb2d_pkg::OP_W-1:0];
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == LAST_BIT) begin
          cmd.div_init_x = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        if (cnt_r == LAST_BIT) begin
          cnt_nxt   = '0;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (cnt_r == '0) begin
          cmd.save_loss_x = 1'b1;
          cmd.div_init_y  = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        if (cnt_r == DIVY_END) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hdl/rb2d_datapath.sv
// Datapath: configuration, body state, shared multiplier, square root and divider.
`default_nettype none
module rb2d_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rb2d_pkg::rb2d_cmd_t                 cmd,
  input  wire logic                                cfg_we,
  input  wire logic [rb2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rb2d_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_pos_x,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_pos_y,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_angle,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_vel_x,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_vel_y,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_spin,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_pos_x,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_pos_y,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_angle,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_vel_x,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_vel_y,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_spin
);

  logic [16:0]        ts_r;
  logic signed [31:0] gx_r, gy_r;
  logic               kin_r;
  logic [30:0]        ld_r, ad_r;

  logic signed [31:0] pos_x_r, pos_y_r, angle_r, vel_x_r, vel_y_r, spin_r;
  logic signed [31:0] o_pos_x_r, o_pos_y_r, o_angle_r, o_vel_x_r, o_vel_y_r, o_spin_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic               mul_vld_r;
  logic [3:0]         mul_op_r;

  logic [63:0]        sq_sum_r, dvx_r, dvy_r;
  logic [31:0]        fl_r, fa_r;
  logic signed [32:0] dpx_r, dpy_r, dang_r, dgx_r, dgy_r;

  logic [63:0]        sq_n_r;
  logic [32:0]        sq_rem_r;
  logic [31:0]        root_r;
  logic [34:0]        sq_t, sq_trial;
  logic               sq_ge;

  logic [31:0]        dv_rem_r, dv_q_r, lx_r;
  logic [32:0]        dv_t;
  logic               dv_ge;

  logic [31:0]        ax, ay, spin_mag;
  logic signed [31:0] vx_d, vy_d, spin_d;
  logic signed [33:0] spin_sum;

  assign ax       = vel_x_r[31] ? (~vel_x_r + 32'd1) : vel_x_r;
  assign ay       = vel_y_r[31] ? (~vel_y_r + 32'd1) : vel_y_r;
  assign spin_mag = spin_r[31] ? (~spin_r + 32'd1) : spin_r;

  always_comb begin
    mul_a = '0;
    mul_b = {16'd0, ts_r};
    case (cmd.op)
      rb2d_pkg::MO_AXX: begin
        mul_a = {1'b0, ax};
        mul_b = {1'b0, ax};
      end
      rb2d_pkg::MO_AYY: begin
        mul_a = {1'b0, ay};
        mul_b = {1'b0, ay};
      end
      rb2d_pkg::MO_FL:   mul_a = {2'b00, ld_r};
      rb2d_pkg::MO_FA:   mul_a = {2'b00, ad_r};
      rb2d_pkg::MO_DPX:  mul_a = {vel_x_r[31], vel_x_r};
      rb2d_pkg::MO_DPY:  mul_a = {vel_y_r[31], vel_y_r};
      rb2d_pkg::MO_DANG: mul_a = {spin_r[31], spin_r};
      rb2d_pkg::MO_DGX:  mul_a = {gx_r[31], gx_r};
      rb2d_pkg::MO_DGY:  mul_a = {gy_r[31], gy_r};
      rb2d_pkg::MO_MX: begin
        mul_a = {1'b0, ax};
        mul_b = {1'b0, fl_r};
      end
      rb2d_pkg::MO_MY: begin
        mul_a = {1'b0, ay};
        mul_b = {1'b0, fl_r};
      end
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r   <= mul_a * mul_b;
    mul_op_r <= cmd.op;
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_vld_r) begin
      case (mul_op_r)
        rb2d_pkg::MO_AXX:  sq_sum_r <= prod_r[63:0];
        rb2d_pkg::MO_AYY:  sq_sum_r <= sq_sum_r + prod_r[63:0];
        rb2d_pkg::MO_FL:   fl_r <= prod_r[47:16];
        rb2d_pkg::MO_FA:   fa_r <= prod_r[47:16];
        rb2d_pkg::MO_DPX:  dpx_r <= prod_r[48:16];
        rb2d_pkg::MO_DPY:  dpy_r <= prod_r[48:16];
        rb2d_pkg::MO_DANG: dang_r <= prod_r[48:16];
        rb2d_pkg::MO_DGX:  dgx_r <= prod_r[48:16];
        rb2d_pkg::MO_DGY:  dgy_r <= prod_r[48:16];
        rb2d_pkg::MO_MX:   dvx_r <= prod_r[63:0];
        rb2d_pkg::MO_MY:   dvy_r <= prod_r[63:0];
        default:           sq_sum_r <= sq_sum_r;
      endcase
    end
  end

  // Square root, two radicand bits per cycle.
  assign sq_t     = {sq_rem_r, sq_n_r[63:62]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_n_r   <= sq_sum_r;
      sq_rem_r <= '0;
      root_r   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_n_r   <= {sq_n_r[61:0], 2'b00};
      sq_rem_r <= sq_ge ? 33'(sq_t - sq_trial) : sq_t[32:0];
      root_r   <= {root_r[30:0], sq_ge};
    end
  end

  // Restoring divider by the speed, one quotient bit per cycle.
  assign dv_t  = {dv_rem_r, dv_q_r[31]};
  assign dv_ge = (dv_t >= {1'b0, root_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init_x) begin
      dv_rem_r <= dvx_r[63:32];
      dv_q_r   <= dvx_r[31:0];
    end else if (cmd.div_init_y) begin
      dv_rem_r <= dvy_r[63:32];
      dv_q_r   <= dvy_r[31:0];
    end else if (cmd.div_step) begin
      dv_rem_r <= dv_ge ? 32'(dv_t - {1'b0, root_r}) : dv_t[31:0];
      dv_q_r   <= {dv_q_r[30:0], dv_ge};
    end
    if (cmd.save_loss_x) begin
      lx_r <= dv_q_r;
    end
  end

  always_comb begin
    vx_d = vel_x_r;
    vy_d = vel_y_r;
    if (root_r != '0) begin
      if (root_r < fl_r) begin
        vx_d = '0;
        vy_d = '0;
      end else begin
        vx_d = vel_x_r[31] ? (vel_x_r + lx_r) : (vel_x_r - lx_r);
        vy_d = vel_y_r[31] ? (vel_y_r + dv_q_r) : (vel_y_r - dv_q_r);
      end
    end
    spin_sum = spin_r[31] ? ({{2{spin_r[31]}}, spin_r} + {2'b00, fa_r})
                          : ({{2{spin_r[31]}}, spin_r} - {2'b00, fa_r});
    spin_d   = (spin_mag < fa_r) ? '0 : spin_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= rb2d_pkg::TIME_STEP_RST;
      gx_r    <= '0;
      gy_r    <= '0;
      kin_r   <= 1'b0;
      ld_r    <= rb2d_pkg::LINEAR_DRAG_RST;
      ad_r    <= rb2d_pkg::ANGULAR_DRAG_RST;
      pos_x_r <= '0;
      pos_y_r <= '0;
      angle_r <= '0;
      vel_x_r <= '0;
      vel_y_r <= '0;
      spin_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rb2d_pkg::CFG_TIME_STEP:    ts_r  <= cfg_data[16:0];
          rb2d_pkg::CFG_GRAVITY_X:    gx_r  <= cfg_data;
          rb2d_pkg::CFG_GRAVITY_Y:    gy_r  <= cfg_data;
          rb2d_pkg::CFG_IS_KINEMATIC: kin_r <= cfg_data[0];
          rb2d_pkg::CFG_LINEAR_DRAG:  ld_r  <= cfg_data[30:0];
          rb2d_pkg::CFG_ANGULAR_DRAG: ad_r  <= cfg_data[30:0];
          default:                    kin_r <= kin_r;
        endcase
      end
      if (cmd.load) begin
        pos_x_r <= in_pos_x;
        pos_y_r <= in_pos_y;
        angle_r <= in_angle;
        vel_x_r <= in_vel_x;
        vel_y_r <= in_vel_y;
        spin_r  <= in_spin;
      end else if (cmd.apply) begin
        pos_x_r <= rb2d_pkg::sat34({{2{pos_x_r[31]}}, pos_x_r} + {dpx_r[32], dpx_r});
        pos_y_r <= rb2d_pkg::sat34({{2{pos_y_r[31]}}, pos_y_r} + {dpy_r[32], dpy_r});
        angle_r <= rb2d_pkg::sat34({{2{angle_r[31]}}, angle_r} + {dang_r[32], dang_r});
        spin_r  <= spin_d;
        if (kin_r) begin
          vel_x_r <= vx_d;
          vel_y_r <= vy_d;
        end else begin
          vel_x_r <= rb2d_pkg::sat34({{2{vx_d[31]}}, vx_d} + {dgx_r[32], dgx_r});
          vel_y_r <= rb2d_pkg::sat34({{2{vy_d[31]}}, vy_d} + {dgy_r[32], dgy_r});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      o_pos_x_r <= pos_x_r;
      o_pos_y_r <= pos_y_r;
      o_angle_r <= angle_r;
      o_vel_x_r <= vel_x_r;
      o_vel_y_r <= vel_y_r;
      o_spin_r  <= spin_r;
    end
  end

  assign out_pos_x = o_pos_x_r;
  assign out_pos_y = o_pos_y_r;
  assign out_angle = o_angle_r;
  assign out_vel_x = o_vel_x_r;
  assign out_vel_y = o_vel_y_r;
  assign out_spin  = o_spin_r;

endmodule
`default_nettype wire

>>> hdl/rigid_body_2d_euler_step_unit.sv
// Top level of the 2D rigid body explicit Euler step unit.
//
//   Channel  Ports                        Beat
//   in       in_valid / in_ready          command and state to load
//   out      out_valid / out_ready        body state after the item
//   cfg      cfg_we, cfg_index, cfg_data  one register write per cycle
//
// A load beat passes through the accepting cycle and S_PUT, which registers the result.
// A step beat passes through the accepting cycle, the shared multiplier, the square root,
// the shared divider for x and then y, S_APPLY and S_PUT, which registers the result.
// Reset is synchronous and active low; it restores the register defaults and a zero state.
// A result held on a stalled output does not block acceptance of the next beat; it only
// holds back the registering of the next result.
`default_nettype none
module rigid_body_2d_euler_step_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_command,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_pos_x,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_pos_y,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_angle,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_vel_x,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_vel_y,
  input  wire logic signed [rb2d_pkg::WORD_W-1:0]  in_spin,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_pos_x,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_pos_y,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_angle,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_vel_x,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_vel_y,
  output logic signed [rb2d_pkg::WORD_W-1:0]       out_spin,
  input  wire logic                                cfg_we,
  input  wire logic [rb2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rb2d_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rb2d_pkg::rb2d_cmd_t cmd;

  rb2d_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  rb2d_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_angle  (in_angle),
    .in_vel_x  (in_vel_x),
    .in_vel_y  (in_vel_y),
    .in_spin   (in_spin),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_angle (out_angle),
    .out_vel_x (out_vel_x),
    .out_vel_y (out_vel_y),
    .out_spin  (out_spin)
  );

endmodule
`default_nettype wire

>>> tb/sv/rigid_body_2d_euler_step_unit_tb.sv
// Self-checking testbench for the 2D rigid body Euler step unit.
`timescale 1ns / 100ps
`default_nettype none
module rigid_body_2d_euler_step_unit_tb;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;
  localparam int   IDLE_LIMIT = 20000;

  typedef logic signed [rb2d_pkg::WORD_W-1:0] word_t;

  typedef struct packed {
    logic  command;
    word_t pos_x, pos_y, angle, vel_x, vel_y, spin;
  } body_beat_t;

  typedef struct packed {
    word_t pos_x, pos_y, angle, vel_x, vel_y, spin;
  } body_state_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_command;
  word_t in_pos_x, in_pos_y, in_angle, in_vel_x, in_vel_y, in_spin;
  logic out_valid, out_ready;
  word_t out_pos_x, out_pos_y, out_angle, out_vel_x, out_vel_y, out_spin;
  logic cfg_we;
  logic [rb2d_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rb2d_pkg::CFG_DATA_W-1:0] cfg_data;

  rigid_body_2d_euler_step_unit u_dut (.*);

  // Predictor copies of the registers and body state.
  longint unsigned dt_q, drag_lin_q, drag_ang_q;
  longint grav_x_q, grav_y_q;
  bit kinematic_q;
  longint bx, by, bang, bvx, bvy, bspin;

  body_beat_t  pending_beats[$];
  body_state_t expected_states[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  sender_hold = 0;
  int  burst_left = 0, gap_left = 0;
  int  stall_phase = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scale_by_dt(longint v);
    return (v * longint'(dt_q)) >>> rb2d_pkg::FRAC_W;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint drag_component(longint c, longint unsigned d,
                                            longint unsigned spd);
    longint unsigned m, loss;
    m = (c < 0) ? longint'(-c) : c;
    loss = (m * d) / spd;
    return (c < 0) ? c + longint'(loss) : c - longint'(loss);
  endfunction

  task automatic apply_cfg_model(logic [rb2d_pkg::CFG_IDX_W-1:0] idx,
                                 logic [rb2d_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      rb2d_pkg::CFG_TIME_STEP:    dt_q = 64'(val[rb2d_pkg::TS_W-1:0]);
      rb2d_pkg::CFG_GRAVITY_X:    grav_x_q = longint'($signed(val));
      rb2d_pkg::CFG_GRAVITY_Y:    grav_y_q = longint'($signed(val));
      rb2d_pkg::CFG_IS_KINEMATIC: kinematic_q = val[0];
      rb2d_pkg::CFG_LINEAR_DRAG:  drag_lin_q = 64'(val[rb2d_pkg::DRAG_W-1:0]);
      rb2d_pkg::CFG_ANGULAR_DRAG: drag_ang_q = 64'(val[rb2d_pkg::DRAG_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic predict_body(body_beat_t b);
    longint unsigned fl, ax, ay, spd;
    longint fa;
    body_state_t s;
    if (b.command == CMD_LOAD) begin
      bx = longint'(b.pos_x); by = longint'(b.pos_y); bang = longint'(b.angle);
      bvx = longint'(b.vel_x); bvy = longint'(b.vel_y); bspin = longint'(b.spin);
    end else begin
      fl = (drag_lin_q * dt_q) >> rb2d_pkg::FRAC_W;
      fa = longint'((drag_ang_q * dt_q) >> rb2d_pkg::FRAC_W);
      ax = (bvx < 0) ? -bvx : bvx;
      ay = (bvy < 0) ? -bvy : bvy;
      spd = root_floor(ax * ax + ay * ay);
      bx = clamp_word(bx + scale_by_dt(bvx));
      by = clamp_word(by + scale_by_dt(bvy));
      bang = clamp_word(bang + scale_by_dt(bspin));
      if (spd != 0) begin
        if (spd < fl) begin
          bvx = '0; bvy = '0;
        end else begin
          bvx = drag_component(bvx, fl, spd);
          bvy = drag_component(bvy, fl, spd);
        end
      end
      if (bspin < 0) bspin = (-bspin < fa) ? '0 : bspin + fa;
      else if (bspin > 0) bspin = (bspin < fa) ? '0 : bspin - fa;
      if (!kinematic_q) begin
        bvx = clamp_word(bvx + scale_by_dt(grav_x_q));
        bvy = clamp_word(bvy + scale_by_dt(grav_y_q));
      end
    end
    s.pos_x = bx[31:0]; s.pos_y = by[31:0]; s.angle = bang[31:0];
    s.vel_x = bvx[31:0]; s.vel_y = bvy[31:0]; s.spin = bspin[31:0];
    expected_states = {expected_states, s};
  endtask

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_body({in_command, in_pos_x, in_pos_y,
                                              in_angle, in_vel_x, in_vel_y, in_spin});
      if (!in_valid || in_ready) begin
        if (gap_left > 0) gap_left--;
        if (pending_beats.size() != 0 && !sender_hold && gap_left == 0) begin
          {in_command, in_pos_x, in_pos_y, in_angle, in_vel_x, in_vel_y, in_spin}
            <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and stalls the receiver on its own pattern.
  always @(posedge clk) begin
    body_state_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_states.size() == 0) begin
          $display("unexpected result beat at %0t", $time);
          error_count++;
        end else begin
          want = expected_states.pop_front();
          if (out_pos_x !== want.pos_x) report_mismatch("pos_x", out_pos_x, want.pos_x);
          if (out_pos_y !== want.pos_y) report_mismatch("pos_y", out_pos_y, want.pos_y);
          if (out_angle !== want.angle) report_mismatch("angle", out_angle, want.angle);
          if (out_vel_x !== want.vel_x) report_mismatch("vel_x", out_vel_x, want.vel_x);
          if (out_vel_y !== want.vel_y) report_mismatch("vel_y", out_vel_y, want.vel_y);
          if (out_spin !== want.spin) report_mismatch("spin", out_spin, want.spin);
        end
      end
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase[8]) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic word_t edge_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 0;
      3: return -1;
      4: return $urandom_range(0, 32'h000FFFFF);
      5: return -$urandom_range(0, 32'h000FFFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_load(word_t px, py, an, vx, vy, sp);
    body_beat_t b;
    b = {CMD_LOAD, px, py, an, vx, vy, sp};
    pending_beats = {pending_beats, b};
  endtask

  task automatic queue_step();
    body_beat_t b;
    b = {CMD_STEP, word_t'($urandom), word_t'($urandom), word_t'($urandom),
         word_t'($urandom), word_t'($urandom), word_t'($urandom)};
    pending_beats = {pending_beats, b};
  endtask

  task automatic drain_results();
    while (pending_beats.size() != 0 || in_valid || expected_states.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_cfg(logic [rb2d_pkg::CFG_IDX_W-1:0] idx,
                           logic [rb2d_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_cfg_model(idx, val);
  endtask

  task automatic random_phase(int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 3)
        queue_load(edge_word(), edge_word(), edge_word(), edge_word(), edge_word(),
                   edge_word());
      else
        queue_step();
    end
  endtask

  initial begin
    in_valid = 0; in_command = 0;
    in_pos_x = 0; in_pos_y = 0; in_angle = 0; in_vel_x = 0; in_vel_y = 0; in_spin = 0;
    out_ready = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    dt_q = 64'd1092; grav_x_q = '0; grav_y_q = '0; kinematic_q = 0;
    drag_lin_q = 64'd6553600; drag_ang_q = 64'd3276800;
    bx = '0; by = '0; bang = '0; bvx = '0; bvy = '0; bspin = '0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset defaults, extremes, zero speed, slow velocity, both spin signs.
    queue_step();
    queue_load(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
               32'sh80000000, 32'sh80000000);
    queue_step();
    queue_load(0, 0, 0, 0, 0, 32'sh00001000);
    queue_step();
    queue_load(0, 0, 0, 32'sh00000100, -32'sh00000080, -32'sh00000100);
    queue_step();
    queue_load(0, 0, 0, 32'sh00500000, -32'sh00300000, -32'sh00400000);
    repeat (4) queue_step();
    drain_results();

    write_cfg(rb2d_pkg::CFG_TIME_STEP, 32'h1FFFF);
    write_cfg(rb2d_pkg::CFG_GRAVITY_X, 32'h80000000);
    write_cfg(rb2d_pkg::CFG_GRAVITY_Y, 32'h7FFFFFFF);
    write_cfg(rb2d_pkg::CFG_LINEAR_DRAG, 32'h7FFFFFFF);
    write_cfg(rb2d_pkg::CFG_ANGULAR_DRAG, 32'h7FFFFFFF);
    queue_load(32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 32'sh7FFFFFFF,
               32'sh7FFFFFFF, 32'sh7FFFFFFF);
    repeat (3) queue_step();
    drain_results();

    write_cfg(rb2d_pkg::CFG_TIME_STEP, 0);
    write_cfg(rb2d_pkg::CFG_IS_KINEMATIC, 1);
    write_cfg(rb2d_pkg::CFG_LINEAR_DRAG, 0);
    write_cfg(rb2d_pkg::CFG_ANGULAR_DRAG, 0);
    random_phase(120);
    drain_results();

    repeat (5) begin
      write_cfg(rb2d_pkg::CFG_TIME_STEP, $urandom_range(0, 131071));
      write_cfg(rb2d_pkg::CFG_GRAVITY_X, $urandom);
      write_cfg(rb2d_pkg::CFG_GRAVITY_Y,
                ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'hFFFFF));
      write_cfg(rb2d_pkg::CFG_IS_KINEMATIC, $urandom_range(0, 1));
      write_cfg(rb2d_pkg::CFG_LINEAR_DRAG,
                ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'hFFFFFF));
      write_cfg(rb2d_pkg::CFG_ANGULAR_DRAG,
                ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'hFFFFFF));
      random_phase(60);
      sender_hold = 1;
      while (expected_states.size() != 0 || in_valid) @(posedge clk);
      sender_hold = 0;
      random_phase(60);
      drain_results();
    end

    write_cfg(rb2d_pkg::CFG_TIME_STEP, 1092);
    write_cfg(rb2d_pkg::CFG_GRAVITY_X, 0);
    write_cfg(rb2d_pkg::CFG_GRAVITY_Y, 32'hFFF63D71);
    write_cfg(rb2d_pkg::CFG_IS_KINEMATIC, 0);
    write_cfg(rb2d_pkg::CFG_LINEAR_DRAG, 6553600);
    write_cfg(rb2d_pkg::CFG_ANGULAR_DRAG, 3276800);
    random_phase(30);
    drain_results();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
hdl/rb2d_pkg.sv
hdl/rb2d_ctrl.sv
hdl/rb2d_datapath.sv
hdl/rigid_body_2d_euler_step_unit.sv
tb/sv/rigid_body_2d_euler_step_unit_tb.sv
